>>> hdl/ipg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_pkg
// Widths, register indexes and tables shared by the ground-plane projector.
// ----------------------------------------------------------------------------
package ipg_pkg;

	localparam int M_W    = 32;   // matrix entry, signed fixed point
	localparam int ADJ_W  = 65;   // adjugate entry
	localparam int DET_W  = 99;   // determinant and camera-centre terms
	localparam int HD_W   = 132;  // h*det + b_z*2^16
	localparam int PIX_W  = 16;
	localparam int AP_W   = 82;   // adjugate entry times pixel coordinate
	localparam int A_W    = 84;   // ray terms
	localparam int DEN_W  = 183;
	localparam int NUM_W  = 217;
	localparam int OUT_W  = 32;

	// homogeneous 1.0 in Q12.4 is a left shift by four
	localparam int ONE_SHIFT = 4;

	localparam int PIX_DLY = 7;
	localparam int A_STG   = 3;
	localparam int BIG_STG = 15;
	localparam int Q_BITS  = 33;
	localparam int DIV_LAT = Q_BITS + 3;

	typedef enum logic [2:0] {
		REG_R0C01  = 3'd0,
		REG_R0C23  = 3'd1,
		REG_R1C01  = 3'd2,
		REG_R1C23  = 3'd3,
		REG_R2C01  = 3'd4,
		REG_R2C23  = 3'd5,
		REG_HEIGHT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} pix_t;

	// adjugate entry k = m[r0][c0]*m[r1][c1] - m[r2][c2]*m[r3][c3], row-major
	localparam int ADJ_SEL [9][8] = '{
		'{1, 1, 2, 2, 1, 2, 2, 1},
		'{0, 2, 2, 1, 0, 1, 2, 2},
		'{0, 1, 1, 2, 0, 2, 1, 1},
		'{1, 2, 2, 0, 1, 0, 2, 2},
		'{0, 0, 2, 2, 0, 2, 2, 0},
		'{0, 2, 1, 0, 0, 0, 1, 2},
		'{1, 0, 2, 1, 1, 1, 2, 0},
		'{0, 1, 2, 0, 0, 0, 2, 1},
		'{0, 0, 1, 1, 0, 1, 1, 0}
	};

endpackage
`default_nettype wire

>>> hdl/ipg_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_mul
// Pipelined signed multiplier, at most one 33x33 limb product per stage.
// ----------------------------------------------------------------------------
module ipg_mul #(
	parameter int AW     = 32,
	parameter int BW     = 32,
	parameter int STAGES = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic signed [AW-1:0]  a,
	input  wire logic signed [BW-1:0]  b,
	output logic signed [AW+BW-1:0]    p
);

	localparam int PW = AW + BW;
	localparam int NA = (AW + 31) / 32;
	localparam int NB = (BW + 31) / 32;
	localparam int NP = NA * NB;

	logic signed [NA*32-1:0] a_s   [STAGES];
	logic signed [NB*32-1:0] b_s   [STAGES];
	logic signed [PW-1:0]    acc_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam int LI = k % NA;
		localparam int LJ = k / NA;
		logic signed [NA*32-1:0] a_src;
		logic signed [NB*32-1:0] b_src;
		logic signed [PW-1:0]    acc_src;
		logic signed [PW-1:0]    pp;

		if (k == 0) begin : g_first
			assign a_src   = (NA*32)'(a);
			assign b_src   = (NB*32)'(b);
			assign acc_src = '0;
		end else begin : g_next
			assign a_src   = a_s[k-1];
			assign b_src   = b_s[k-1];
			assign acc_src = acc_s[k-1];
		end

		if (k < NP) begin : g_pp
			logic signed [32:0] la;
			logic signed [32:0] lb;
			logic signed [65:0] prod;
			// only the top limb of each operand carries the sign
			if (LI == NA - 1) begin : g_la_top
				assign la = $signed({a_src[LI*32+31], a_src[LI*32 +: 32]});
			end else begin : g_la_low
				assign la = $signed({1'b0, a_src[LI*32 +: 32]});
			end
			if (LJ == NB - 1) begin : g_lb_top
				assign lb = $signed({b_src[LJ*32+31], b_src[LJ*32 +: 32]});
			end else begin : g_lb_low
				assign lb = $signed({1'b0, b_src[LJ*32 +: 32]});
			end
			assign prod = la * lb;
			assign pp   = PW'(prod) <<< (32 * (LI + LJ));
		end else begin : g_nopp
			assign pp = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_s[k]   <= '0;
				b_s[k]   <= '0;
				acc_s[k] <= '0;
			end else if (en) begin
				a_s[k]   <= a_src;
				b_s[k]   <= b_src;
				acc_s[k] <= acc_src + pp;
			end
		end
	end

	assign p = acc_s[STAGES-1];

endmodule
`default_nettype wire

>>> hdl/ipg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipg_div
// Pipelined signed divide, one quotient bit per stage, rounded and saturated.
// ----------------------------------------------------------------------------
module ipg_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic signed [ipg_pkg::NUM_W-1:0]  num,
	input  wire logic signed [ipg_pkg::DEN_W-1:0]  den,
	input  wire logic                              kill,
	output logic signed [ipg_pkg::OUT_W-1:0]       q,
	output logic                                   kill_o
);

	import ipg_pkg::*;

	localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [Q_BITS:0]  LIM_POS = (Q_BITS+1)'(SAT_POS);
	localparam logic [Q_BITS:0]  LIM_NEG = (Q_BITS+1)'(SAT_NEG);

	logic [NUM_W-1:0] un_s1;
	logic [DEN_W-1:0] ud_s1;
	logic             neg_s1, kill_s1;

	logic [NUM_W-1:0] r_s2;
	logic [DEN_W-1:0] ud_s2;
	logic             neg_s2, kill_s2, ovf_s2;

	logic [NUM_W-1:0]  r_b    [Q_BITS];
	logic [Q_BITS-1:0] q_b    [Q_BITS];
	logic [DEN_W-1:0]  ud_b   [Q_BITS];
	logic              neg_b  [Q_BITS];
	logic              ovf_b  [Q_BITS];
	logic              kill_b [Q_BITS];

	logic             up;
	logic [Q_BITS:0]  qr;
	logic [OUT_W-1:0] res;

	always_ff @(posedge clk) begin
		if (en) begin
			un_s1   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			ud_s1   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			neg_s1  <= num[NUM_W-1] ^ den[DEN_W-1];
			kill_s1 <= kill;
			// quotient of 2^32 or more saturates in any case
			ovf_s2  <= un_s1 >= NUM_W'({ud_s1, 32'd0});
			r_s2    <= un_s1;
			ud_s2   <= ud_s1;
			neg_s2  <= neg_s1;
			kill_s2 <= kill_s1;
		end
	end

	for (genvar t = 0; t < Q_BITS; t++) begin : g_bit
		localparam int BI = Q_BITS - 1 - t;
		logic [NUM_W-1:0]  r_src;
		logic [Q_BITS-1:0] q_src;
		logic [DEN_W-1:0]  ud_src;
		logic              neg_src, ovf_src, kill_src;
		logic [NUM_W-1:0]  cand;
		logic              ge;

		if (t == 0) begin : g_first
			assign r_src    = r_s2;
			assign q_src    = '0;
			assign ud_src   = ud_s2;
			assign neg_src  = neg_s2;
			assign ovf_src  = ovf_s2;
			assign kill_src = kill_s2;
		end else begin : g_next
			assign r_src    = r_b[t-1];
			assign q_src    = q_b[t-1];
			assign ud_src   = ud_b[t-1];
			assign neg_src  = neg_b[t-1];
			assign ovf_src  = ovf_b[t-1];
			assign kill_src = kill_b[t-1];
		end

		assign cand = NUM_W'(ud_src) << BI;
		assign ge   = r_src >= cand;

		always_ff @(posedge clk) begin
			if (en) begin
				r_b[t]    <= ge ? r_src - cand : r_src;
				q_b[t]    <= q_src | (Q_BITS'(ge) << BI);
				ud_b[t]   <= ud_src;
				neg_b[t]  <= neg_src;
				ovf_b[t]  <= ovf_src;
				kill_b[t] <= kill_src;
			end
		end
	end

	// round half away from zero on the magnitude
	always_comb begin
		up = (r_b[Q_BITS-1] << 1) >= NUM_W'(ud_b[Q_BITS-1]);
		qr = (Q_BITS+1)'(q_b[Q_BITS-1]) + (Q_BITS+1)'(up);
		if (kill_b[Q_BITS-1]) begin
			res = '0;
		end else if (neg_b[Q_BITS-1]) begin
			res = (ovf_b[Q_BITS-1] || qr > LIM_NEG) ? SAT_NEG : OUT_W'(-qr);
		end else begin
			res = (ovf_b[Q_BITS-1] || qr > LIM_POS) ? SAT_POS : qr[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q      <= '0;
			kill_o <= 1'b0;
		end else if (en) begin
			q      <= $signed(res);
			kill_o <= kill_b[Q_BITS-1];
		end
	end

endmodule
`default_nettype wire

>>> hdl/image_point_to_ground_plane_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_point_to_ground_plane_core
// Back-projects an image point through a pinhole camera onto the plane z = h.
// One point per cycle while the output handshake does not stall.
// The rate is set by a fully pipelined datapath: limb multipliers and a
// one-bit-per-stage divider, all stalled together by the output handshake.
// Reset clears the configuration registers to zero; matrix-derived terms
// settle through free-running registers after a register write.
// ----------------------------------------------------------------------------
module image_point_to_ground_plane_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [2:0]                         cfg_index,
	input  wire logic [63:0]                        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [ipg_pkg::PIX_W-1:0]          pixel_x,
	input  wire logic [ipg_pkg::PIX_W-1:0]          pixel_y,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [ipg_pkg::OUT_W-1:0]        world_x,
	output logic signed [ipg_pkg::OUT_W-1:0]        world_y,
	output logic signed [ipg_pkg::OUT_W-1:0]        world_z,
	output logic                                    invalid
);

	import ipg_pkg::*;

	localparam int LAT = PIX_DLY + A_STG + 1 + BIG_STG + 1 + DIV_LAT;

	logic [63:0]              mat_q [6];
	logic signed [M_W-1:0]    height_q;
	logic signed [M_W-1:0]    m [3][4];

	logic signed [63:0]       adj_p [9];
	logic signed [63:0]       adj_n [9];
	logic signed [ADJ_W-1:0]  adj_q [9];
	logic signed [96:0]       db_p  [12];
	logic signed [DET_W-1:0]  det_sum;
	logic signed [DET_W-1:0]  det_q;
	logic signed [DET_W-1:0]  b_q [3];
	logic                     det_zero_q;
	logic signed [130:0]      hd_p;
	logic signed [HD_W-1:0]   hd_q;

	logic                     en;
	logic                     v_s [LAT];
	pix_t                     pix_s [PIX_DLY];
	logic signed [AP_W-1:0]   ap [6];
	logic signed [A_W-1:0]    a_sum [3];
	logic signed [A_W-1:0]    a_s11 [3];
	logic                     inv_s11;
	logic                     inv_d_s [BIG_STG];
	logic signed [A_W+HD_W-1:0]  axhd, ayhd;
	logic signed [DET_W+A_W-1:0] bxaz, byaz, den_p;
	logic signed [NUM_W-1:0]  num_x_s27, num_y_s27;
	logic signed [DEN_W-1:0]  den_s27;
	logic                     kill_s27;
	logic                     inv_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) mat_q[i] <= '0;
			height_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index) inside
				[REG_R0C01:REG_R2C23]: mat_q[cfg_index] <= cfg_data;
				REG_HEIGHT:            height_q <= $signed(cfg_data[31:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			m[r][0] = $signed(mat_q[2*r][31:0]);
			m[r][1] = $signed(mat_q[2*r][63:32]);
			m[r][2] = $signed(mat_q[2*r+1][31:0]);
			m[r][3] = $signed(mat_q[2*r+1][63:32]);
		end
	end

	// matrix-derived terms, free running off the registers
	for (genvar k = 0; k < 9; k++) begin : g_adj
		ipg_mul #(.AW(M_W), .BW(M_W), .STAGES(1)) u_p (
			.clk(clk), .arst_n(arst_n), .en(1'b1),
			.a(m[ADJ_SEL[k][0]][ADJ_SEL[k][1]]), .b(m[ADJ_SEL[k][2]][ADJ_SEL[k][3]]),
			.p(adj_p[k])
		);
		ipg_mul #(.AW(M_W), .BW(M_W), .STAGES(1)) u_n (
			.clk(clk), .arst_n(arst_n), .en(1'b1),
			.a(m[ADJ_SEL[k][4]][ADJ_SEL[k][5]]), .b(m[ADJ_SEL[k][6]][ADJ_SEL[k][7]]),
			.p(adj_n[k])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) adj_q[k] <= '0;
			else         adj_q[k] <= ADJ_W'(adj_p[k]) - ADJ_W'(adj_n[k]);
		end
	end

	// terms 0..2 build the determinant, 3..11 the products adj * column 3
	for (genvar k = 0; k < 12; k++) begin : g_db
		if (k < 3) begin : g_det
			ipg_mul #(.AW(M_W), .BW(ADJ_W), .STAGES(3)) u_m (
				.clk(clk), .arst_n(arst_n), .en(1'b1),
				.a(m[0][k]), .b(adj_q[k*3]), .p(db_p[k])
			);
		end else begin : g_b
			ipg_mul #(.AW(M_W), .BW(ADJ_W), .STAGES(3)) u_m (
				.clk(clk), .arst_n(arst_n), .en(1'b1),
				.a(m[(k-3)%3][3]), .b(adj_q[k-3]), .p(db_p[k])
			);
		end
	end

	assign det_sum = DET_W'(db_p[0]) + DET_W'(db_p[1]) + DET_W'(db_p[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q      <= '0;
			det_zero_q <= 1'b1;
			for (int i = 0; i < 3; i++) b_q[i] <= '0;
		end else begin
			det_q      <= det_sum;
			det_zero_q <= det_sum == '0;
			for (int i = 0; i < 3; i++) begin
				b_q[i] <= DET_W'(db_p[3+3*i]) + DET_W'(db_p[4+3*i]) + DET_W'(db_p[5+3*i]);
			end
		end
	end

	ipg_mul #(.AW(M_W), .BW(DET_W), .STAGES(4)) u_hd (
		.clk(clk), .arst_n(arst_n), .en(1'b1),
		.a(height_q), .b(det_q), .p(hd_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hd_q <= '0;
		else         hd_q <= HD_W'(hd_p) + (HD_W'(b_q[2]) <<< 16);
	end

	// point pipeline, all stages move together
	assign en        = !v_s[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++) v_s[i] <= v_s[i-1];
		end
	end

	// delay lets the matrix terms of a fresh write reach the point datapath
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s[0] <= '{x: pixel_x, y: pixel_y};
			for (int i = 1; i < PIX_DLY; i++) pix_s[i] <= pix_s[i-1];
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_ap
		logic signed [PIX_W:0] coord;
		assign coord = (k % 2 == 0) ? $signed({1'b0, pix_s[PIX_DLY-1].x})
		                            : $signed({1'b0, pix_s[PIX_DLY-1].y});
		ipg_mul #(.AW(ADJ_W), .BW(PIX_W+1), .STAGES(A_STG)) u_m (
			.clk(clk), .arst_n(arst_n), .en(en),
			.a(adj_q[(k/2)*3 + (k%2)]), .b(coord), .p(ap[k])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_sum[i] = A_W'(ap[2*i]) + A_W'(ap[2*i+1]) + (A_W'(adj_q[3*i+2]) <<< ONE_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) a_s11[i] <= a_sum[i];
			inv_s11    <= det_zero_q || (a_sum[2] == '0);
			inv_d_s[0] <= inv_s11;
			for (int i = 1; i < BIG_STG; i++) inv_d_s[i] <= inv_d_s[i-1];
		end
	end

	ipg_mul #(.AW(A_W), .BW(HD_W), .STAGES(BIG_STG)) u_axhd (
		.clk(clk), .arst_n(arst_n), .en(en), .a(a_s11[0]), .b(hd_q), .p(axhd)
	);
	ipg_mul #(.AW(A_W), .BW(HD_W), .STAGES(BIG_STG)) u_ayhd (
		.clk(clk), .arst_n(arst_n), .en(en), .a(a_s11[1]), .b(hd_q), .p(ayhd)
	);
	ipg_mul #(.AW(DET_W), .BW(A_W), .STAGES(BIG_STG)) u_bxaz (
		.clk(clk), .arst_n(arst_n), .en(en), .a(b_q[0]), .b(a_s11[2]), .p(bxaz)
	);
	ipg_mul #(.AW(DET_W), .BW(A_W), .STAGES(BIG_STG)) u_byaz (
		.clk(clk), .arst_n(arst_n), .en(en), .a(b_q[1]), .b(a_s11[2]), .p(byaz)
	);
	ipg_mul #(.AW(DET_W), .BW(A_W), .STAGES(BIG_STG)) u_den (
		.clk(clk), .arst_n(arst_n), .en(en), .a(det_q), .b(a_s11[2]), .p(den_p)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s27 <= NUM_W'(axhd) - (NUM_W'(bxaz) <<< 16);
			num_y_s27 <= NUM_W'(ayhd) - (NUM_W'(byaz) <<< 16);
			den_s27   <= DEN_W'(den_p);
			kill_s27  <= inv_d_s[BIG_STG-1];
		end
	end

	ipg_div u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(num_x_s27), .den(den_s27), .kill(kill_s27),
		.q(world_x), .kill_o(invalid)
	);

	ipg_div u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(num_y_s27), .den(den_s27), .kill(kill_s27),
		.q(world_y), .kill_o(inv_y)
	);

	assign world_z = invalid ? '0 : height_q;

`ifndef SYNTH
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> world_x == '0 && world_y == '0 && world_z == '0)
		else $error("invalid result with nonzero coordinates");

	a_z_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> world_z == height_q)
		else $error("world_z differs from plane height");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline is stalled");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s[0])
		else $error("accepted transaction not tracked in pipeline");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inv_y == invalid)
		else $error("divider lanes disagree on invalid flag");
`endif

endmodule
`default_nettype wire
